// File: design/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

  // Source formats held in the format register; other codes give black.
  typedef enum logic [2:0] {
    FmtIndexed8 = 3'd0,
    FmtRgb555   = 3'd1,
    FmtRgb565   = 3'd2,
    FmtBgr24    = 3'd3,
    FmtBgrx32   = 3'd4
  } fmt_e;

  localparam int unsigned PalDepth = 256;
  localparam int unsigned PalAddrW = $clog2(PalDepth);

  // Divisors for widening 5-bit and 6-bit channels to full scale.
  localparam int unsigned Div5 = 31;
  localparam int unsigned Div6 = 63;

  // Rounded-up reciprocals of the divisors, scaled by 2^18 and 2^20. Both are
  // exact over the whole range of c * 255 for their channel width.
  localparam int unsigned Recip5 = ((2 ** 18) + Div5 - 1) / Div5;
  localparam int unsigned Recip6 = ((2 ** 20) + Div6 - 1) / Div6;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One access to the palette: a read for a convert beat or a write.
  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic [PalAddrW-1:0] addr;
    rgb_t                wr_data;
  } pal_req_t;

  // c * 255 / 31, rounded down, by multiplying with the scaled reciprocal.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] prod;
    logic [26:0] scaled;
    prod   = {8'b0, c} * 13'd255;
    scaled = 27'(prod) * 27'(Recip5);
    return scaled[25:18];
  endfunction

  // c * 255 / 63, rounded down, by multiplying with the scaled reciprocal.
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] prod;
    logic [28:0] scaled;
    prod   = {8'b0, c} * 14'd255;
    scaled = 29'(prod) * 29'(Recip6);
    return scaled[27:20];
  endfunction

endpackage

`default_nettype wire

// File: design/pfr_palette.sv
`default_nettype none

module pfr_palette (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pfr_pkg::pal_req_t req_i,
  output pfr_pkg::rgb_t          rd_data_o
);
  import pfr_pkg::*;

  rgb_t                mem_q [PalDepth];
  logic [PalDepth-1:0] written_q;
  rgb_t                rd_data_q;
  logic                rd_hit_q;

  // Palette storage; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.addr];
    end
  end

  // One written flag per entry stands in for clearing the array at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_hit_q <= written_q[req_i.addr];
      end
    end
  end

  // An entry never written reads as black.
  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// File: design/pfr_convert.sv
`default_nettype none

module pfr_convert (
  input  wire logic [2:0]    fmt_i,
  input  wire logic [23:0]   pixel_i,
  input  wire pfr_pkg::rgb_t pal_i,
  output pfr_pkg::rgb_t      rgb_o
);
  import pfr_pkg::*;

  // Channel decode for each source format.
  always_comb begin
    rgb_o = '0;
    unique case (fmt_e'(fmt_i))
      FmtIndexed8: begin
        rgb_o = pal_i;
      end
      FmtRgb555: begin
        rgb_o.red   = expand5(pixel_i[14:10]);
        rgb_o.green = expand5(pixel_i[9:5]);
        rgb_o.blue  = expand5(pixel_i[4:0]);
      end
      FmtRgb565: begin
        rgb_o.red   = expand5(pixel_i[15:11]);
        rgb_o.green = expand6(pixel_i[10:5]);
        rgb_o.blue  = expand5(pixel_i[4:0]);
      end
      FmtBgr24, FmtBgrx32: begin
        rgb_o.red   = pixel_i[23:16];
        rgb_o.green = pixel_i[15:8];
        rgb_o.blue  = pixel_i[7:0];
      end
      default: begin
        rgb_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/pixel_format_to_rgb888_core.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o   mode, pixel_word, entry_index, entry_r/g/b
// out       output     out_valid_o/out_stall_i out_red, out_green, out_blue
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (source format)
//
// One beat is accepted per cycle while the input is not stalled; a convert beat
// passes through the palette read stage and then the output register.
// Palette writes give no output and take effect for the very next beat.
// Reset clears the format register and marks every palette entry unwritten at once,
// so there is no clearing pass. The input stalls only while both the palette read
// stage and the output register hold beats and the output is stalled.

module pixel_format_to_rgb888_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [31:0] pixel_word_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [7:0]  entry_red_i,
  input  wire logic [7:0]  entry_green_i,
  input  wire logic [7:0]  entry_blue_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_data_i
);
  import pfr_pkg::*;

  logic [2:0]  fmt_q;
  logic        s1_valid_q;
  logic [23:0] s1_pixel_q;
  logic        out_valid_q;
  rgb_t        out_rgb_q;
  logic        s1_move;
  logic        in_accept;
  pal_req_t    pal_req;
  rgb_t        pal_data;
  rgb_t        conv_rgb;

  // Format register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 3'(FmtIndexed8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= cfg_data_i;
    end
  end

  // Flow control: the read stage moves on when the output register is free.
  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Palette access for the accepted beat.
  always_comb begin
    pal_req.rd_en   = in_accept && !mode_i;
    pal_req.wr_en   = in_accept && mode_i;
    pal_req.addr    = mode_i ? entry_index_i : pixel_word_i[7:0];
    pal_req.wr_data = '{red: entry_red_i, green: entry_green_i, blue: entry_blue_i};
  end

  pfr_palette u_palette (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (pal_req),
    .rd_data_o (pal_data)
  );

  // Read stage: holds a convert beat while its palette data is fetched. It
  // loads whenever it is empty or its beat moves on to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_accept && !mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && !mode_i) begin
      s1_pixel_q <= pixel_word_i[23:0];
    end
  end

  pfr_convert u_convert (
    .fmt_i   (fmt_q),
    .pixel_i (s1_pixel_q),
    .pal_i   (pal_data),
    .rgb_o   (conv_rgb)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_rgb_q <= conv_rgb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_rgb_q.red;
  assign out_green_o = out_rgb_q.green;
  assign out_blue_o  = out_rgb_q.blue;

`ifndef SYNTHESIS
  // The input stalls only when both stages are full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  // An accepted convert beat always lands in the read stage.
  a_convert_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !mode_i |=> s1_valid_q)
    else $error("convert beat lost on entry");

  // A held read stage keeps its palette data.
  a_hold_pal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(pal_data))
    else $error("palette data changed while the read stage was held");

  // A palette write accepted into an empty read stage never produces an output beat.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && mode_i && !s1_valid_q && s1_move |=> !s1_valid_q)
    else $error("palette write entered the read stage");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfr_pkg::*;

  // Beat kinds on the input channel.
  localparam logic ModeConvert  = 1'b0;
  localparam logic ModePalWrite = 1'b1;

  // Receiver hold-off used to fill the block, and the no-progress limit.
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned StuckLimit    = 2000;
  localparam int unsigned DrainCycles   = 4;

  typedef struct {
    logic       mode;
    logic [31:0] pixel;
    logic [7:0] index;
    rgb_t       colour;
  } beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        mode_i        = 1'b0;
  logic [31:0] pixel_word_i  = '0;
  logic [7:0]  entry_index_i = '0;
  logic [7:0]  entry_red_i   = '0;
  logic [7:0]  entry_green_i = '0;
  logic [7:0]  entry_blue_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i    = '0;

  pixel_format_to_rgb888_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .pixel_word_i  (pixel_word_i),
    .entry_index_i (entry_index_i),
    .entry_red_i   (entry_red_i),
    .entry_green_i (entry_green_i),
    .entry_blue_i  (entry_blue_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Testbench copy of the block's state, and the traffic queues.
  rgb_t        palette_copy [PalDepth];
  logic [2:0]  format_copy = FmtIndexed8;
  beat_t       pending_beats [$];
  rgb_t        expected_pixels [$];
  beat_t       beat_on_port;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned stuck_cycles  = 0;
  int unsigned errors        = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Widen a 5-bit or 6-bit channel to full scale, rounding down.
  function automatic logic [7:0] scale5(input logic [4:0] c);
    int unsigned v;
    v = 32'(c) * 255 / 31;
    return v[7:0];
  endfunction

  function automatic logic [7:0] scale6(input logic [5:0] c);
    int unsigned v;
    v = 32'(c) * 255 / 63;
    return v[7:0];
  endfunction

  // Convert one source pixel under the given format; unknown formats give black.
  function automatic rgb_t to_rgb888(input logic [2:0] fmt, input logic [31:0] px);
    rgb_t c;
    c = '0;
    case (fmt)
      FmtIndexed8: c = palette_copy[px[7:0]];
      FmtRgb555: begin
        c.red   = scale5(px[14:10]);
        c.green = scale5(px[9:5]);
        c.blue  = scale5(px[4:0]);
      end
      FmtRgb565: begin
        c.red   = scale5(px[15:11]);
        c.green = scale6(px[10:5]);
        c.blue  = scale5(px[4:0]);
      end
      FmtBgr24, FmtBgrx32: c = px[23:0];
      default: c = '0;
    endcase
    return c;
  endfunction

  // An accepted beat either loads the palette or yields one converted pixel.
  task automatic apply_beat(input beat_t b);
    if (b.mode == ModePalWrite) begin
      palette_copy[b.index] = b.colour;
    end else begin
      expected_pixels.push_back(to_rgb888(format_copy, b.pixel));
    end
  endtask

  // Driver: holds a stalled beat, otherwise offers the next pending one or idles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_beat(beat_on_port);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_port = pending_beats.pop_front();
          mode_i        <= beat_on_port.mode;
          pixel_word_i  <= beat_on_port.pixel;
          entry_index_i <= beat_on_port.index;
          entry_red_i   <= beat_on_port.colour.red;
          entry_green_i <= beat_on_port.colour.green;
          entry_blue_i  <= beat_on_port.colour.blue;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output beat against the oldest expected pixel and
  // drives the stall, including the occasional long hold-off.
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected output %02h %02h %02h",
                                    out_red_o, out_green_o, out_blue_o));
        end else begin
          want = expected_pixels.pop_front();
          if (out_red_o !== want.red)
            report_mismatch($sformatf("red got %02h want %02h", out_red_o, want.red));
          if (out_green_o !== want.green)
            report_mismatch($sformatf("green got %02h want %02h", out_green_o, want.green));
          if (out_blue_o !== want.blue)
            report_mismatch($sformatf("blue got %02h want %02h", out_blue_o, want.blue));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no channel makes progress for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no beat accepted for %0d cycles", StuckLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_convert(input logic [31:0] px);
    beat_t b;
    b = '{mode: ModeConvert, pixel: px, index: 8'($urandom()),
          colour: rgb_t'(24'($urandom()))};
    pending_beats.push_back(b);
  endtask

  task automatic push_write(input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    beat_t w;
    w = '{mode: ModePalWrite, pixel: $urandom(), index: idx, colour: {r, g, b}};
    pending_beats.push_back(w);
  endtask

  function automatic beat_t rand_beat(input int unsigned write_pct);
    beat_t b;
    b.mode = ($urandom_range(99) < write_pct) ? ModePalWrite : ModeConvert;
    case ($urandom_range(15))
      0:       b.pixel = '0;
      1:       b.pixel = '1;
      default: b.pixel = $urandom();
    endcase
    // Keep many indices in a narrow band so that reads hit written entries.
    if ($urandom_range(1) != 0) b.pixel[7:0] = 8'($urandom_range(15));
    b.index = ($urandom_range(1) != 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    b.colour = rgb_t'(24'($urandom()));
    return b;
  endfunction

  // Wait until every beat is sent and every pixel received, then let any
  // trailing palette write settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_pixels.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_format(input logic [2:0] fmt);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fmt;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    format_copy = fmt;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    foreach (palette_copy[i]) palette_copy[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Indexed: cleared palette, upper pixel bits ignored, write then read at once.
    push_convert(32'h0000_0000);
    push_convert(32'hFFFF_FFFF);
    push_write(8'h00, 8'hFF, 8'h00, 8'hFF);
    push_write(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_convert(32'hFFFF_FF00);
    push_convert(32'h0000_00FF);
    push_write(8'h5A, 8'h12, 8'h34, 8'h56);
    push_convert(32'h0000_005A);

    // RGB555: full scale, ignored top bit, ignored upper half, mid value.
    set_format(FmtRgb555);
    push_convert(32'h0000_7FFF);
    push_convert(32'h0000_8000);
    push_convert(32'hFFFF_0000);
    push_convert(32'h0000_4210);
    push_write(8'h01, 8'h00, 8'h00, 8'h00);

    // RGB565: extremes and the smallest non-zero channels.
    set_format(FmtRgb565);
    push_convert(32'h0000_FFFF);
    push_convert(32'hFFFF_0000);
    push_convert(32'h0000_0821);

    // BGR24 and BGRX32: the top byte never shows.
    set_format(FmtBgr24);
    push_convert(32'hFFFF_FFFF);
    push_convert(32'hAA12_3456);
    set_format(FmtBgrx32);
    push_convert(32'h0000_0000);
    push_convert(32'hFF00_FF00);

    // Unknown formats give black; a palette write still gives nothing.
    set_format(3'd7);
    push_convert(32'hFFFF_FFFF);
    push_write(8'h80, 8'hFF, 8'hFF, 8'hFF);
    set_format(3'd5);
    push_convert(32'h1234_5678);

    // Random traffic under every format and three idling profiles.
    for (int p = 0; p < 3; p++) begin
      for (int c = 0; c < 8; c++) begin
        set_format(3'(c));
        case (p)
          0: begin send_idle_pct = 8;  recv_idle_pct = 52; end
          1: begin send_idle_pct = 52; recv_idle_pct = 8;  end
          default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        for (int n = 0; n < 62; n++) begin
          pending_beats.push_back(rand_beat((c == 0) ? 30 : 10));
        end
        // Hold the output off while the sender keeps offering beats.
        if (p == 0 && c == 1) hold_requests++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
